[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define ASSERT_SAME(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[rtl/core/dsb_pkg.sv]
// ----------------------------------------------------------------------------
// dsb_pkg
// Types, constants and helper functions of the distinct sort bitmap unit.
// ----------------------------------------------------------------------------
package dsb_pkg;

    // value range and derived widths
    localparam int VALUE_RANGE = 1024;
    localparam int VAL_W       = 10;
    localparam int CNT_W       = $clog2(VALUE_RANGE + 1);
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int NUM_WORDS   = VALUE_RANGE / WORD_W;
    localparam int WIDX_W      = $clog2(NUM_WORDS);

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;      // input transfer this cycle
        logic ins_commit;  // read data valid, finish insert
        logic drn_commit;  // read data valid, finish drain
    } dsb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;    // result register holds an untaken result
    } dsb_status_t;

    // index of the lowest set bit of a bitmap word (zero when none set)
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = i[BIT_W-1:0];
            end
        end
        return idx;
    endfunction

    // index of the lowest nonzero word from the summary bits
    function automatic logic [WIDX_W-1:0] lowest_word(input logic [NUM_WORDS-1:0] s);
        logic [WIDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (s[i]) begin
                idx = i[WIDX_W-1:0];
            end
        end
        return idx;
    endfunction

endpackage

[rtl/core/distinct_sort_bitmap_unit.sv]
// ----------------------------------------------------------------------------
// distinct_sort_bitmap_unit
// Presence-bitmap store that removes duplicates and drains values in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): s_operation 0 inserts s_item_value,
//   1 drains the smallest value held. Inserts give no result; each drain
//   gives one result transfer on the m_ channel with the value, the distinct
//   count before the drain, a last flag and an empty flag.
//   Each item passes an accept step for the bitmap word read (registered
//   RAM read) and a commit step for the read-modify-write; the unit is back
//   in idle right after the commit, so it takes no new item before the last
//   one has committed.
//   A drain's result appears the cycle after its commit.
//   Reset clears the summary bits and the count; RAM words behind a clear
//   summary bit read as zero, so no clearing pass is needed.
//   If the receiver stalls, a result waits in the output register; the unit
//   still accepts the next item, and a following drain holds in its commit
//   cycle until the waiting result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module distinct_sort_bitmap_unit
    import dsb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_operation,
    input  logic [VAL_W-1:0] s_item_value,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [VAL_W-1:0] m_smallest_value,
    output logic [CNT_W-1:0] m_distinct_before,
    output logic             m_is_last,
    output logic             m_was_empty
);

    dsb_cmd_t    cmd;
    dsb_status_t status;

    dsb_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .cmd         (cmd),
        .status      (status)
    );

    dsb_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_operation       (s_operation),
        .s_item_value      (s_item_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_smallest_value  (m_smallest_value),
        .m_distinct_before (m_distinct_before),
        .m_is_last         (m_is_last),
        .m_was_empty       (m_was_empty)
    );

    // an accepted item keeps the input side closed for its commit cycle
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a drain commit always leaves a result in the output register
    `ASSERT_NEXT(a_commit_gives_result, aclk, aresetn, cmd.drn_commit, m_valid)
    // an empty result carries zero fields
    `ASSERT_SAME(a_empty_fields, aclk, aresetn, m_valid && m_was_empty, (m_smallest_value == '0) && (m_distinct_before == '0) && !m_is_last)
    // the last value is drained from a count of one
    `ASSERT_SAME(a_last_count, aclk, aresetn, m_valid && m_is_last, m_distinct_before == CNT_W'(1))

endmodule

[rtl/core/dsb_ram.sv]
// ----------------------------------------------------------------------------
// dsb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/dsb_ctrl.sv]
// ----------------------------------------------------------------------------
// dsb_ctrl
// Controller: accepts one item, waits for the bitmap word, commits the update.
// ----------------------------------------------------------------------------
module dsb_ctrl
    import dsb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_operation,
    output logic        s_ready,
    output dsb_cmd_t    cmd,
    input  dsb_status_t status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_DRN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd.accept     = 1'b0;
        cmd.ins_commit = 1'b0;
        cmd.drn_commit = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_operation == OP_DRAIN) ? S_DRN : S_INS;
                end
            end
            S_INS: begin
                cmd.ins_commit = 1'b1;
                state_next     = S_IDLE;
            end
            S_DRN: begin
                // hold until the result register is free
                if (!status.out_busy) begin
                    cmd.drn_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/dsb_datapath.sv]
// ----------------------------------------------------------------------------
// dsb_datapath
// Two-level bitmap: word RAM plus summary bits, distinct count, result register.
// ----------------------------------------------------------------------------
module dsb_datapath
    import dsb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  dsb_cmd_t           cmd,
    output dsb_status_t        status,
    input  logic               s_operation,
    input  logic [VAL_W-1:0]   s_item_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VAL_W-1:0]   m_smallest_value,
    output logic [CNT_W-1:0]   m_distinct_before,
    output logic               m_is_last,
    output logic               m_was_empty
);

    // summary: one bit per RAM word, set when that word holds any value;
    // a word with a clear summary bit reads as zero
    logic [NUM_WORDS-1:0] summary_reg, summary_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [VAL_W-1:0]     val_reg;
    logic [WIDX_W-1:0]    widx_reg;
    logic [WIDX_W-1:0]    rd_widx;

    logic                 out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]     out_value_reg;
    logic [CNT_W-1:0]     out_before_reg;
    logic                 out_last_reg;
    logic                 out_empty_reg;

    logic [WORD_W-1:0]    rd_data;
    logic [WORD_W-1:0]    word;
    logic [WORD_W-1:0]    new_word;
    logic [BIT_W-1:0]     ins_bit;
    logic [BIT_W-1:0]     low_bit;
    logic                 wr_en;
    logic                 ins_new;
    logic                 drn_hit;

    // read address: insert word, or lowest nonzero word for a drain
    assign rd_widx = (s_operation == OP_DRAIN) ? lowest_word(summary_reg)
                                               : s_item_value[VAL_W-1:BIT_W];

    dsb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (widx_reg),
        .wr_data (new_word),
        .rd_en   (cmd.accept),
        .rd_addr (rd_widx),
        .rd_data (rd_data)
    );

    // word contents, masked by the summary bit
    assign word    = summary_reg[widx_reg] ? rd_data : '0;
    assign ins_bit = val_reg[BIT_W-1:0];
    assign low_bit = lowest_bit(word);
    assign ins_new = cmd.ins_commit && !word[ins_bit]
                     && (32'(val_reg) < VALUE_RANGE);
    assign drn_hit = cmd.drn_commit && (count_reg != '0);
    assign wr_en   = ins_new || drn_hit;

    // updated word for insert or drain
    always_comb begin
        new_word = word;
        if (cmd.ins_commit) begin
            new_word[ins_bit] = 1'b1;
        end else begin
            new_word[low_bit] = 1'b0;
        end
    end

    // summary and count updates
    always_comb begin
        summary_next = summary_reg;
        count_next   = count_reg;
        if (ins_new) begin
            summary_next[widx_reg] = 1'b1;
            count_next             = count_reg + CNT_W'(1);
        end else if (drn_hit) begin
            summary_next[widx_reg] = |new_word;
            count_next             = count_reg - CNT_W'(1);
        end
    end

    // result register valid
    always_comb begin
        if (cmd.drn_commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            summary_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            summary_reg   <= summary_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item latch and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            val_reg  <= s_item_value;
            widx_reg <= rd_widx;
        end
        if (cmd.drn_commit) begin
            if (count_reg == '0) begin
                out_value_reg  <= '0;
                out_before_reg <= '0;
                out_last_reg   <= 1'b0;
                out_empty_reg  <= 1'b1;
            end else begin
                out_value_reg  <= {widx_reg, low_bit};
                out_before_reg <= count_reg;
                out_last_reg   <= (count_reg == CNT_W'(1));
                out_empty_reg  <= 1'b0;
            end
        end
    end

    assign status.out_busy   = out_valid_reg && !m_ready;
    assign m_valid           = out_valid_reg;
    assign m_smallest_value  = out_value_reg;
    assign m_distinct_before = out_before_reg;
    assign m_is_last         = out_last_reg;
    assign m_was_empty       = out_empty_reg;

endmodule
